FILE: rtl/acs_pkg.sv
// Shared types and register codes for the animation channel sequencer.
package acs_pkg;

   typedef enum logic [1:0] {
      CH_TEX,
      CH_COL,
      CH_GEO
   } ch_kind_type;

   typedef enum logic [2:0] {
      CSR_CHANNEL_ENABLE,
      CSR_TIME_LIMIT,
      CSR_TEX_DELAY,
      CSR_COL_DELAY,
      CSR_GEO_DELAY,
      CSR_BLINK_DELAY,
      CSR_STAGE_COUNTS,
      CSR_LOOP_COUNTS
   } csr_index_type;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_TICK  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic take;
      logic expire;
   } step_type;

   localparam int CH_NUM      = 4;
   localparam int CH_BLINK    = 3;
   localparam int FIELD_WIDTH = 8;
   localparam int DELAY_WIDTH = 16;
   localparam int PACK_WIDTH  = 24;
   localparam int NOW_WIDTH   = 32;

endpackage

FILE: rtl/acs_stage_step.sv
// Step decision and next stage and loop count for one staged channel.
module acs_stage_step #(
   parameter int COUNT_WIDTH = 8,
   parameter int TIME_WIDTH  = 32
) (
   input  acs_pkg::ch_kind_type                kind,
   input  logic                                run,
   input  logic [TIME_WIDTH-1:0]               now,
   input  logic [TIME_WIDTH-1:0]               last,
   input  logic [acs_pkg::DELAY_WIDTH-1:0]     delay,
   input  logic [acs_pkg::FIELD_WIDTH-1:0]     stages,
   input  logic [acs_pkg::FIELD_WIDTH-1:0]     loops,
   input  logic [COUNT_WIDTH-1:0]              stage,
   input  logic [COUNT_WIDTH-1:0]              loops_left,
   output logic [COUNT_WIDTH-1:0]              stage_next,
   output logic [COUNT_WIDTH-1:0]              loops_left_next,
   output acs_pkg::step_type                   step
);

   localparam int CMP_WIDTH =
      ((COUNT_WIDTH > acs_pkg::FIELD_WIDTH) ? COUNT_WIDTH : acs_pkg::FIELD_WIDTH) + 1;
   localparam int DIFF_WIDTH =
      (TIME_WIDTH > acs_pkg::DELAY_WIDTH) ? TIME_WIDTH : acs_pkg::DELAY_WIDTH;

   logic [TIME_WIDTH-1:0]  diff;
   logic                   due;
   logic [CMP_WIDTH-1:0]   stage_p1;
   logic                   at_end;
   logic [COUNT_WIDTH-1:0] stage_inc;

   assign diff = now - last;
   assign due  = (delay == '0) || (DIFF_WIDTH'(diff) > DIFF_WIDTH'(delay));
   assign stage_p1  = CMP_WIDTH'(stage) + CMP_WIDTH'(1);
   assign stage_inc = stage + COUNT_WIDTH'(1);
   assign at_end = (stage_p1 >= CMP_WIDTH'(stages)) &&
                   ((kind == acs_pkg::CH_TEX) || (stages != '0));

   always_comb begin
      stage_next      = stage;
      loops_left_next = loops_left;
      step.take       = run && due;
      step.expire     = 1'b0;
      if (step.take) begin
         if (at_end) begin
            if (loops != '0) begin
               if (loops_left <= COUNT_WIDTH'(1)) begin
                  step.expire = 1'b1;
               end else begin
                  loops_left_next = loops_left - COUNT_WIDTH'(1);
                  stage_next      = '0;
               end
            end else if (kind == acs_pkg::CH_TEX) begin
               stage_next = '0;
            end
         end else if (kind == acs_pkg::CH_COL) begin
            if (stage != '1) begin
               stage_next = stage_inc;
            end
         end else begin
            stage_next = stage_inc;
         end
      end
   end

endmodule

FILE: rtl/animation_channel_sequencer.sv
// Four-channel animation sequencer: texture, color, geometry and blink timing.
// One request per clock while rsp_stall is low: a request is taken into an input
// register, and once the result register is free or read, a single pass of compare
// and counter logic updates the channel state and loads the result register, which
// offers the response; requests may follow back to back. The longest path is the
// lifetime compare, the texture step and the dependent color/geometry step.
module animation_channel_sequencer #(
   parameter int COUNT_WIDTH = 8,
   parameter int TIME_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tex_stage,
   output logic [7:0]  rsp_col_stage,
   output logic [7:0]  rsp_geo_stage,
   output logic [3:0]  rsp_stepped,
   output logic [3:0]  rsp_expired_mask,
   output logic        rsp_all_expired,
   output logic        rsp_blink_on,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int LIM_WIDTH =
      (TIME_WIDTH > acs_pkg::DELAY_WIDTH) ? TIME_WIDTH : acs_pkg::DELAY_WIDTH;
   localparam int FW = acs_pkg::FIELD_WIDTH;

   // configuration
   logic [acs_pkg::CH_NUM-1:0]      enable_ff;
   logic [acs_pkg::DELAY_WIDTH-1:0] limit_ff;
   logic [acs_pkg::DELAY_WIDTH-1:0] delay_ff [acs_pkg::CH_NUM];
   logic [acs_pkg::PACK_WIDTH-1:0]  stages_ff;
   logic [acs_pkg::PACK_WIDTH-1:0]  loops_ff;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_type_ff;
   logic [TIME_WIDTH-1:0] in_now_ff;
   logic                  advance;

   // channel state
   logic [TIME_WIDTH-1:0]     start_ff, start_in;
   logic [TIME_WIDTH-1:0]     last_ff [acs_pkg::CH_NUM];
   logic [TIME_WIDTH-1:0]     last_in [acs_pkg::CH_NUM];
   logic [COUNT_WIDTH-1:0]    stage_ff [3];
   logic [COUNT_WIDTH-1:0]    stage_in [3];
   logic [COUNT_WIDTH-1:0]    loops_left_ff [3];
   logic [COUNT_WIDTH-1:0]    loops_left_in [3];
   logic [acs_pkg::CH_NUM-1:0] expired_ff, expired_in;
   logic                      blink_ff, blink_in;
   logic [acs_pkg::CH_NUM-1:0] stepped_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] tex_stage_ff, col_stage_ff, geo_stage_ff;
   logic [3:0] stepped_ff, expired_mask_ff;
   logic       all_expired_ff, blink_on_ff;

   // step logic
   logic [TIME_WIDTH-1:0]      start_diff;
   logic                       limit_hit;
   logic [acs_pkg::CH_NUM-1:0] exp0, exp1;
   logic                       tex_run, col_run, geo_run;
   logic [TIME_WIDTH-1:0]      blink_diff;
   logic                       blink_take;
   logic [COUNT_WIDTH-1:0]     st_next [3];
   logic [COUNT_WIDTH-1:0]     lp_next [3];
   acs_pkg::step_type          tex_step, col_step, geo_step;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         limit_ff  <= '0;
         stages_ff <= '0;
         loops_ff  <= '0;
         for (int i = 0; i < acs_pkg::CH_NUM; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (acs_pkg::csr_index_type'(csr_index))
            acs_pkg::CSR_CHANNEL_ENABLE: enable_ff <= csr_data[acs_pkg::CH_NUM-1:0];
            acs_pkg::CSR_TIME_LIMIT:     limit_ff <= csr_data[acs_pkg::DELAY_WIDTH-1:0];
            acs_pkg::CSR_TEX_DELAY:      delay_ff[0] <= csr_data[acs_pkg::DELAY_WIDTH-1:0];
            acs_pkg::CSR_COL_DELAY:      delay_ff[1] <= csr_data[acs_pkg::DELAY_WIDTH-1:0];
            acs_pkg::CSR_GEO_DELAY:      delay_ff[2] <= csr_data[acs_pkg::DELAY_WIDTH-1:0];
            acs_pkg::CSR_BLINK_DELAY:    delay_ff[3] <= csr_data[acs_pkg::DELAY_WIDTH-1:0];
            acs_pkg::CSR_STAGE_COUNTS:   stages_ff <= csr_data;
            acs_pkg::CSR_LOOP_COUNTS:    loops_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // handshake
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_type_ff <= req_type;
         in_now_ff  <= TIME_WIDTH'(req_now_ms);
      end
   end

   // tick evaluation
   assign start_diff = in_now_ff - start_ff;
   assign limit_hit  = (limit_ff != '0) && (LIM_WIDTH'(start_diff) > LIM_WIDTH'(limit_ff));
   assign exp0       = limit_hit ? '1 : expired_ff;
   assign tex_run    = !exp0[0];
   assign exp1       = {exp0[3:1], exp0[0] | tex_step.expire};
   assign col_run    = !exp0[1] && exp1[0];
   assign geo_run    = !exp0[2] && exp1[0];
   assign blink_diff = in_now_ff - last_ff[acs_pkg::CH_BLINK];
   assign blink_take = !exp0[acs_pkg::CH_BLINK] &&
                       ((delay_ff[acs_pkg::CH_BLINK] == '0) ||
                        (LIM_WIDTH'(blink_diff) > LIM_WIDTH'(delay_ff[acs_pkg::CH_BLINK])));

   acs_stage_step #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_tex (
      .kind            (acs_pkg::CH_TEX),
      .run             (tex_run),
      .now             (in_now_ff),
      .last            (last_ff[0]),
      .delay           (delay_ff[0]),
      .stages          (stages_ff[FW-1:0]),
      .loops           (loops_ff[FW-1:0]),
      .stage           (stage_ff[0]),
      .loops_left      (loops_left_ff[0]),
      .stage_next      (st_next[0]),
      .loops_left_next (lp_next[0]),
      .step            (tex_step)
   );

   acs_stage_step #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_col (
      .kind            (acs_pkg::CH_COL),
      .run             (col_run),
      .now             (in_now_ff),
      .last            (last_ff[1]),
      .delay           (delay_ff[1]),
      .stages          (stages_ff[2*FW-1:FW]),
      .loops           (loops_ff[2*FW-1:FW]),
      .stage           (stage_ff[1]),
      .loops_left      (loops_left_ff[1]),
      .stage_next      (st_next[1]),
      .loops_left_next (lp_next[1]),
      .step            (col_step)
   );

   acs_stage_step #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_geo (
      .kind            (acs_pkg::CH_GEO),
      .run             (geo_run),
      .now             (in_now_ff),
      .last            (last_ff[2]),
      .delay           (delay_ff[2]),
      .stages          (stages_ff[3*FW-1:2*FW]),
      .loops           (loops_ff[3*FW-1:2*FW]),
      .stage           (stage_ff[2]),
      .loops_left      (loops_left_ff[2]),
      .stage_next      (st_next[2]),
      .loops_left_next (lp_next[2]),
      .step            (geo_step)
   );

   always_comb begin
      start_in   = start_ff;
      expired_in = expired_ff;
      blink_in   = blink_ff;
      stepped_in = '0;
      for (int i = 0; i < acs_pkg::CH_NUM; i++) begin
         last_in[i] = last_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         stage_in[i]      = stage_ff[i];
         loops_left_in[i] = loops_left_ff[i];
      end
      unique case (acs_pkg::req_kind_type'(in_type_ff))
         acs_pkg::REQ_START: begin
            start_in   = in_now_ff;
            expired_in = ~enable_ff;
            for (int i = 0; i < 3; i++) begin
               if (enable_ff[i]) begin
                  last_in[i]       = in_now_ff;
                  stage_in[i]      = '0;
                  loops_left_in[i] = COUNT_WIDTH'(loops_ff[FW*i +: FW]);
               end
            end
            if (enable_ff[acs_pkg::CH_BLINK]) begin
               last_in[acs_pkg::CH_BLINK] = in_now_ff;
            end
         end
         acs_pkg::REQ_TICK: begin
            expired_in = {exp1[3], exp1[2] | geo_step.expire,
                          exp1[1] | col_step.expire, exp1[0]};
            for (int i = 0; i < 3; i++) begin
               stage_in[i]      = st_next[i];
               loops_left_in[i] = lp_next[i];
            end
            if (tex_step.take) last_in[0] = in_now_ff;
            if (col_step.take) last_in[1] = in_now_ff;
            if (geo_step.take) last_in[2] = in_now_ff;
            stepped_in[0] = tex_step.take && !tex_step.expire;
            stepped_in[1] = col_step.take && !col_step.expire;
            stepped_in[2] = geo_step.take && !geo_step.expire;
            if (blink_take) begin
               last_in[acs_pkg::CH_BLINK]    = in_now_ff;
               blink_in                      = !blink_ff;
               stepped_in[acs_pkg::CH_BLINK] = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         expired_ff <= '1;
         blink_ff   <= 1'b0;
         for (int i = 0; i < acs_pkg::CH_NUM; i++) begin
            last_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            stage_ff[i]      <= '0;
            loops_left_ff[i] <= '0;
         end
      end else if (advance) begin
         start_ff   <= start_in;
         expired_ff <= expired_in;
         blink_ff   <= blink_in;
         for (int i = 0; i < acs_pkg::CH_NUM; i++) begin
            last_ff[i] <= last_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            stage_ff[i]      <= stage_in[i];
            loops_left_ff[i] <= loops_left_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tex_stage_ff    <= 8'(stage_in[0]);
         col_stage_ff    <= 8'(stage_in[1]);
         geo_stage_ff    <= 8'(stage_in[2]);
         stepped_ff      <= stepped_in;
         expired_mask_ff <= expired_in;
         all_expired_ff  <= &expired_in;
         blink_on_ff     <= blink_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tex_stage    = tex_stage_ff;
   assign rsp_col_stage    = col_stage_ff;
   assign rsp_geo_stage    = geo_stage_ff;
   assign rsp_stepped      = stepped_ff;
   assign rsp_expired_mask = expired_mask_ff;
   assign rsp_all_expired  = all_expired_ff;
   assign rsp_blink_on     = blink_on_ff;

endmodule
